@@ src/riq_pkg.sv @@
package riq_pkg;

  localparam int MAX_COLS = 32;
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int CNT_W = COL_W + 1;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWLEN = 1'b1;

  localparam logic [CNT_W-1:0] ROWLEN_RESET = CNT_W'(MAX_COLS);

  localparam logic [31:0] FLOOR_BITS = 32'h322B_CC77;
  localparam logic [31:0] SEVEN_BITS = 32'h40E0_0000;
  localparam logic [14:0] HALF_INF = 15'h7C00;
  localparam logic [23:0] HALF_RND = 24'h00_1000;

  typedef enum logic [1:0] {
    KIND_SCALE = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_OUTL  = 2'd2
  } kind_t;

  typedef struct packed {
    logic             st_we;
    logic [COL_W-1:0] st_addr;
    logic             rd_en;
    logic [COL_W-1:0] idx;
    logic             scan;
    logic             scan_clr;
    logic             div_scale;
    logic             div_inv;
    logic             mul;
    logic             qnt;
    logic             emit;
    kind_t            emit_kind;
    logic             emit_last;
    logic             row_done;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
    logic outl_flag;
  } sts_t;

  function automatic logic [15:0] half_from_single(input logic [31:0] u);
    logic              sgn;
    logic [22:0]       man;
    logic [23:0]       man24;
    logic signed [9:0] e;
    logic [4:0]        sh;
    logic [10:0]       rnd;
    logic [15:0]       r;
    sgn = u[31];
    man = u[22:0];
    man24 = {1'b1, man};
    e = $signed({2'b00, u[30:23]}) - 10'sd112;
    sh = '0;
    rnd = '0;
    if (e < -10'sd10) begin
      r = {sgn, 15'h0000};
    end else if (e <= 10'sd0) begin
      sh = 5'(10'sd14 - e);
      r = {sgn, 5'h00, 10'(man24 >> sh)};
    end else if (e >= 10'sd31) begin
      r = {sgn, HALF_INF};
    end else begin
      rnd = 11'(({1'b0, man} + HALF_RND) >> 13);
      r = {sgn, 15'({e[4:0], 10'h000} + {4'h0, rnd})};
    end
    return r;
  endfunction

endpackage

@@ src/riq_fdiv.sv @@
module riq_fdiv
  import riq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] q,
  output logic        done
);

  typedef enum logic [1:0] {
    SP_NORM,
    SP_INF,
    SP_ZERO
  } spec_t;

  logic        busy_r, fin_r, done_r;
  logic [4:0]  cnt_r;
  logic [25:0] rem_r;
  logic [24:0] quo_r;
  logic [23:0] den_r;
  logic [9:0]  exp_r;
  spec_t       spec_r;
  logic [31:0] res_r;

  logic [23:0] ma, mb;
  logic        lt;
  logic        ge;
  logic [25:0] diff;
  logic [23:0] m_pre;
  logic [24:0] m_rnd;
  logic        inc;
  logic [9:0]  e_fin;
  logic [22:0] m_fin;

  assign ma = {1'b1, a[22:0]};
  assign mb = {1'b1, b[22:0]};
  assign lt = ma < mb;
  assign ge = rem_r >= {2'b00, den_r};
  assign diff = ge ? rem_r - {2'b00, den_r} : rem_r;

  assign m_pre = quo_r[24:1];
  assign inc = quo_r[0] & ((rem_r != '0) | m_pre[0]);
  assign m_rnd = {1'b0, m_pre} + {24'h0, inc};
  assign e_fin = m_rnd[24] ? exp_r + 10'd1 : exp_r;
  assign m_fin = m_rnd[24] ? 23'h0 : m_rnd[22:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= fin_r;
      fin_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd24) begin
          busy_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= mb;
      rem_r <= lt ? {1'b0, ma, 1'b0} : {2'b00, ma};
      exp_r <= {2'b00, a[30:23]} - {2'b00, b[30:23]} + 10'd127 - {9'h0, lt};
      quo_r <= '0;
      if (&a[30:23]) begin
        spec_r <= SP_INF;
      end else if (&b[30:23]) begin
        spec_r <= SP_ZERO;
      end else begin
        spec_r <= SP_NORM;
      end
    end else if (busy_r) begin
      quo_r <= {quo_r[23:0], ge};
      rem_r <= {diff[24:0], 1'b0};
    end
    if (fin_r) begin
      unique case (spec_r)
        SP_INF:  res_r <= 32'h7F80_0000;
        SP_ZERO: res_r <= 32'h0000_0000;
        default: res_r <= {1'b0, e_fin[7:0], m_fin};
      endcase
    end
  end

  assign q = res_r;
  assign done = done_r;

endmodule

@@ src/riq_dpath.sv @@
module riq_dpath
  import riq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic [31:0]          in_sample,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [31:0]          cfg_wdata,
  input  logic                 out_ready,
  output logic                 out_valid,
  output kind_t                out_kind,
  output logic [31:0]          out_row,
  output logic [COL_W-1:0]     out_col,
  output logic [15:0]          out_payload,
  output logic                 out_last
);

  typedef enum logic [1:0] {
    PC_ZERO,
    PC_CLAMP,
    PC_NORM
  } pcls_t;

  logic [31:0] store_r [MAX_COLS];
  logic [31:0] rd_data_r;
  logic [31:0] thr_r;
  logic [31:0] max_r, peak_r;
  logic [MAX_COLS-1:0] outl_r;
  logic        scan_d_r;
  logic [COL_W-1:0] idx_d_r;
  logic [31:0] row_cnt_r;
  logic [7:0]  byte_r;

  logic        mul_sign_r;
  logic [47:0] mul_p_r;
  logic [9:0]  mul_e_r;
  pcls_t       mul_cls_r;

  logic        out_valid_r;
  kind_t       out_kind_r;
  logic [31:0] out_row_r;
  logic [COL_W-1:0] out_col_r;
  logic [15:0] out_payload_r;
  logic        out_last_r;

  logic        detect;
  logic [31:0] a_mag;
  logic        a_nan, is_outl;
  logic [31:0] floored;
  logic        div_start, div_done;
  logic [31:0] div_a, div_b, div_q;

  logic        x_nan, x_inf, x_small, i_zero;
  pcls_t       cls_nxt;

  logic        p_hi, g_bit, s_bit, inc;
  logic [23:0] m_pre, m_fin;
  logic [24:0] m_rnd;
  logic signed [9:0] e1, e2;
  logic [3:0]  nmag, nib;
  logic        big;

  logic        out_free;
  logic [15:0] emit_payload;
  logic [COL_W-1:0] emit_col;

  assign detect = !thr_r[31] && (thr_r[30:0] != '0) &&
                  !((&thr_r[30:23]) && (thr_r[22:0] != '0));
  assign a_mag = {1'b0, rd_data_r[30:0]};
  assign a_nan = (&rd_data_r[30:23]) && (rd_data_r[22:0] != '0);
  assign is_outl = detect && !a_nan && (a_mag > thr_r);
  assign floored = (max_r < FLOOR_BITS) ? FLOOR_BITS : max_r;

  assign div_start = cmd.div_scale | cmd.div_inv;
  assign div_a = cmd.div_scale ? floored : SEVEN_BITS;
  assign div_b = cmd.div_scale ? SEVEN_BITS : peak_r;

  riq_fdiv u_fdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .a     (div_a),
    .b     (div_b),
    .q     (div_q),
    .done  (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.st_we) begin
      store_r[cmd.st_addr] <= in_sample;
    end
    if (cmd.rd_en) begin
      rd_data_r <= store_r[cmd.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
      max_r <= '0;
      peak_r <= '0;
      scan_d_r <= 1'b0;
      row_cnt_r <= '0;
    end else begin
      if (cfg_we && cfg_addr == CFG_THRESH) begin
        thr_r <= cfg_wdata;
      end
      scan_d_r <= cmd.scan;
      if (cmd.scan_clr) begin
        max_r <= '0;
      end else if (scan_d_r && !is_outl && !a_nan && a_mag > max_r) begin
        max_r <= a_mag;
      end
      if (cmd.div_scale) begin
        peak_r <= floored;
      end
      if (cmd.row_done) begin
        row_cnt_r <= row_cnt_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_d_r <= cmd.idx;
    if (scan_d_r) begin
      outl_r[idx_d_r] <= is_outl;
    end
  end

  assign x_nan = (&rd_data_r[30:23]) && (rd_data_r[22:0] != '0);
  assign x_inf = (&rd_data_r[30:23]) && (rd_data_r[22:0] == '0);
  assign x_small = rd_data_r[30:23] == '0;
  assign i_zero = div_q[30:0] == '0;

  always_comb begin
    if (x_nan) begin
      cls_nxt = PC_ZERO;
    end else if (x_inf) begin
      cls_nxt = i_zero ? PC_ZERO : PC_CLAMP;
    end else if (x_small || i_zero) begin
      cls_nxt = PC_ZERO;
    end else begin
      cls_nxt = PC_NORM;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      mul_sign_r <= rd_data_r[31];
      mul_p_r <= {1'b1, rd_data_r[22:0]} * {1'b1, div_q[22:0]};
      mul_e_r <= {2'b00, rd_data_r[30:23]} + {2'b00, div_q[30:23]} - 10'd254;
      mul_cls_r <= cls_nxt;
    end
  end

  assign p_hi = mul_p_r[47];
  assign m_pre = p_hi ? mul_p_r[47:24] : mul_p_r[46:23];
  assign g_bit = p_hi ? mul_p_r[23] : mul_p_r[22];
  assign s_bit = p_hi ? (mul_p_r[22:0] != '0) : (mul_p_r[21:0] != '0);
  assign inc = g_bit & (s_bit | m_pre[0]);
  assign m_rnd = {1'b0, m_pre} + {24'h0, inc};
  assign e1 = $signed(mul_e_r) + $signed({9'h0, p_hi});
  assign e2 = m_rnd[24] ? e1 + 10'sd1 : e1;
  assign m_fin = m_rnd[24] ? 24'h80_0000 : m_rnd[23:0];
  assign big = e2 >= 10'sd3;

  always_comb begin
    if (e2 == -10'sd1) begin
      nmag = 4'd1;
    end else if (e2 == 10'sd0) begin
      nmag = 4'd1 + {3'h0, m_fin[22]};
    end else if (e2 == 10'sd1) begin
      nmag = {2'h0, m_fin[23:22]} + {3'h0, m_fin[21]};
    end else if (e2 == 10'sd2) begin
      nmag = {1'b0, m_fin[23:21]} + {3'h0, m_fin[20]};
    end else begin
      nmag = 4'd0;
    end
    if (mul_cls_r == PC_ZERO) begin
      nib = 4'h0;
    end else if (mul_cls_r == PC_CLAMP || big) begin
      nib = mul_sign_r ? 4'h8 : 4'h7;
    end else if (mul_sign_r) begin
      nib = 4'h0 - nmag;
    end else begin
      nib = (nmag >= 4'd7) ? 4'h7 : nmag;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.qnt) begin
      if (cmd.idx[0]) begin
        byte_r <= {outl_r[cmd.idx] ? 4'h0 : nib, byte_r[3:0]};
      end else begin
        byte_r <= {4'h0, outl_r[cmd.idx] ? 4'h0 : nib};
      end
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    unique case (cmd.emit_kind)
      KIND_SCALE: begin
        emit_payload = half_from_single(div_q);
        emit_col = '0;
      end
      KIND_OUTL: begin
        emit_payload = half_from_single(rd_data_r);
        emit_col = cmd.idx;
      end
      default: begin
        emit_payload = {8'h00, byte_r};
        emit_col = {cmd.idx[COL_W-1:1], 1'b0};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind_r <= cmd.emit_kind;
      out_row_r <= row_cnt_r;
      out_col_r <= emit_col;
      out_payload_r <= emit_payload;
      out_last_r <= cmd.emit_last;
    end
  end

  assign sts.div_done = div_done;
  assign sts.out_free = out_free;
  assign sts.outl_flag = outl_r[cmd.idx];

  assign out_valid = out_valid_r;
  assign out_kind = out_kind_r;
  assign out_row = out_row_r;
  assign out_col = out_col_r;
  assign out_payload = out_payload_r;
  assign out_last = out_last_r;

endmodule

@@ src/riq_ctrl.sv @@
module riq_ctrl
  import riq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [31:0]          cfg_wdata,
  input  sts_t                 sts,
  output cmd_t                 cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_DIV_SCALE,
    S_WAIT_SCALE,
    S_EMIT_SCALE,
    S_DIV_INV,
    S_WAIT_INV,
    S_OUTL_CHK,
    S_OUTL_EMIT,
    S_BYTE_RD,
    S_BYTE_MUL,
    S_BYTE_QNT,
    S_BYTE_EMIT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] col_cnt_r, col_cnt_nxt;
  logic [COL_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] len_r;
  logic [CNT_W-1:0] len_eff;
  logic [COL_W-1:0] last_idx;
  logic             at_last;
  logic [CNT_W-1:0] col_inc;

  always_comb begin
    if (len_r == '0) begin
      len_eff = CNT_W'(1);
    end else if (len_r > CNT_W'(MAX_COLS)) begin
      len_eff = CNT_W'(MAX_COLS);
    end else begin
      len_eff = len_r;
    end
  end

  assign last_idx = COL_W'(len_eff - CNT_W'(1));
  assign at_last = idx_r == last_idx;
  assign col_inc = col_cnt_r + CNT_W'(1);
  assign in_ready = state_r == S_IDLE;

  always_comb begin
    state_nxt = state_r;
    col_cnt_nxt = col_cnt_r;
    idx_nxt = idx_r;
    cmd = '0;
    cmd.idx = idx_r;
    cmd.st_addr = col_cnt_r[COL_W-1:0];
    cmd.emit_kind = KIND_SCALE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.st_we = !col_cnt_r[CNT_W-1];
          if (col_inc >= len_eff) begin
            col_cnt_nxt = '0;
            idx_nxt = '0;
            cmd.scan_clr = 1'b1;
            state_nxt = S_SCAN;
          end else begin
            col_cnt_nxt = col_inc;
          end
        end
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        cmd.scan = 1'b1;
        if (at_last) begin
          state_nxt = S_SCAN_END;
        end else begin
          idx_nxt = idx_r + COL_W'(1);
        end
      end
      S_SCAN_END: state_nxt = S_DIV_SCALE;
      S_DIV_SCALE: begin
        cmd.div_scale = 1'b1;
        state_nxt = S_WAIT_SCALE;
      end
      S_WAIT_SCALE: begin
        if (sts.div_done) begin
          state_nxt = S_EMIT_SCALE;
        end
      end
      S_EMIT_SCALE: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          state_nxt = S_DIV_INV;
        end
      end
      S_DIV_INV: begin
        cmd.div_inv = 1'b1;
        state_nxt = S_WAIT_INV;
      end
      S_WAIT_INV: begin
        if (sts.div_done) begin
          idx_nxt = '0;
          state_nxt = S_OUTL_CHK;
        end
      end
      S_OUTL_CHK: begin
        if (sts.outl_flag) begin
          cmd.rd_en = 1'b1;
          state_nxt = S_OUTL_EMIT;
        end else if (at_last) begin
          idx_nxt = '0;
          state_nxt = S_BYTE_RD;
        end else begin
          idx_nxt = idx_r + COL_W'(1);
        end
      end
      S_OUTL_EMIT: begin
        cmd.emit_kind = KIND_OUTL;
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (at_last) begin
            idx_nxt = '0;
            state_nxt = S_BYTE_RD;
          end else begin
            idx_nxt = idx_r + COL_W'(1);
            state_nxt = S_OUTL_CHK;
          end
        end
      end
      S_BYTE_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_BYTE_MUL;
      end
      S_BYTE_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = S_BYTE_QNT;
      end
      S_BYTE_QNT: begin
        cmd.qnt = 1'b1;
        if (idx_r[0] || at_last) begin
          state_nxt = S_BYTE_EMIT;
        end else begin
          idx_nxt = idx_r + COL_W'(1);
          state_nxt = S_BYTE_RD;
        end
      end
      S_BYTE_EMIT: begin
        cmd.emit_kind = KIND_BYTE;
        cmd.emit_last = at_last;
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (at_last) begin
            cmd.row_done = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + COL_W'(1);
            state_nxt = S_BYTE_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      col_cnt_r <= '0;
      idx_r <= '0;
      len_r <= ROWLEN_RESET;
    end else begin
      state_r <= state_nxt;
      col_cnt_r <= col_cnt_nxt;
      idx_r <= idx_nxt;
      if (cfg_we && cfg_addr == CFG_ROWLEN) begin
        len_r <= cfg_wdata[CNT_W-1:0];
      end
    end
  end

endmodule

@@ src/rowwise_int4_quantizer_unit.sv @@
// Row-wise int4 quantizer. Each request on the in_ channel carries one fp32 value;
// values are buffered until a row of row_length values is complete.
// After the last value of a row the out_ channel returns, in order: one scale
// request (fp16 absmax / 7), one request per outlier in column order (fp16
// value), and one request per packed nibble byte, the last of which has tlast.
// The cfg_ port writes register 0 (outlier threshold, fp32 bits) and
// register 1 (row length) and may only be used while the block is idle.
// Input values are taken one per cycle while a row is filling; in_tready is low
// while a finished row is being processed. A row then goes through a magnitude
// scan, two fp32 divides on the shared divider, a check per column plus an emit
// per outlier, and a read, multiply and round sequence per column plus a byte
// request per column pair. Results sit in a single output register; when the
// receiver stalls, the sequencer waits and resumes without loss. Reset clears
// the row and column counters, sets the row length to 32 and the threshold to
// zero.
module rowwise_int4_quantizer_unit
  import riq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,   // [31:0] sample_bits
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [55:0]          out_tdata,  // [31:0] row_index, [36:32] col_index,
                                           // [52:37] payload, [55:53] zero
  output logic [1:0]           out_tuser,  // [1:0] kind
  output logic                 out_tlast,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [31:0]          cfg_wdata
);

  cmd_t             cmd;
  sts_t             sts;
  kind_t            out_kind;
  logic [31:0]      out_row;
  logic [COL_W-1:0] out_col;
  logic [15:0]      out_payload;

  riq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .sts       (sts),
    .cmd       (cmd)
  );

  riq_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_sample   (in_tdata),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_kind    (out_kind),
    .out_row     (out_row),
    .out_col     (out_col),
    .out_payload (out_payload),
    .out_last    (out_tlast)
  );

  assign out_tdata = {3'b000, out_payload, out_col, out_row};
  assign out_tuser = out_kind;

endmodule

@@ src/riq_checker.sv @@
module riq_checker
  import riq_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic [31:0]          in_tdata,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [55:0]          out_tdata,
  input logic [1:0]           out_tuser,
  input logic                 out_tlast,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_addr,
  input logic [31:0]          cfg_wdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
    && $stable(out_tlast))
    else $error("stalled result changed");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == KIND_SCALE || out_tuser == KIND_BYTE
    || out_tuser == KIND_OUTL)
    else $error("illegal result kind");

  a_last_is_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == KIND_BYTE)
    else $error("row end on a non-byte result");

  a_scale_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_SCALE |-> out_tdata[36:32] == '0 && !out_tlast)
    else $error("scale result with column or last set");

  a_byte_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_BYTE |-> !out_tdata[32] && out_tdata[52:45] == '0)
    else $error("byte result malformed");

endmodule

bind rowwise_int4_quantizer_unit riq_checker u_riq_checker (.*);

@@ bench/tb.sv @@
module tb;
  import riq_pkg::*;

  localparam int LIMIT = 1000000;
  localparam int SETTLE = 300;

  typedef struct {
    kind_t       kind;
    logic [31:0] row;
    logic [4:0]  col;
    logic [15:0] pay;
    logic        last;
  } quant_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;

  quant_result_t pending_results[$];
  int          mismatches = 0;
  int          cycles = 0;
  int          samples_sent = 0;
  bit          calm = 1'b0;

  logic [31:0] thr_reg;
  logic [5:0]  len_reg;
  logic [31:0] row_buf[MAX_COLS];
  int          col_cnt;
  logic [31:0] row_cnt;

  rowwise_int4_quantizer_unit dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 28);
  end

  function automatic real single_to_real(logic [31:0] u);
    real mag;
    if (u[30:23] == 8'hFF)
      return $bitstoreal({u[31], 11'h7FF, (u[22:0] != 0) ? 52'h8_0000_0000_0000 : 52'h0});
    if (u[30:23] == 8'h00) begin
      mag = real'(u[22:0]) * (2.0 ** -149);
      return u[31] ? -mag : mag;
    end
    return $bitstoreal({u[31], 11'(int'(u[30:23]) - 127 + 1023), u[22:0], 29'h0});
  endfunction

  // Round a double to the nearest single, ties to even, with subnormals.
  function automatic logic [31:0] real_to_single(real x);
    logic [63:0] d, m, q, rem, half;
    int e, sh;
    d = $realtobits(x);
    if (d[62:52] == 11'h7FF)
      return (d[51:0] != 0) ? 32'h7FC0_0000 : {d[63], 31'h7F80_0000};
    if (d[62:52] == 11'h000)
      return {d[63], 31'h0};
    e = int'(d[62:52]) - 1023;
    if (e > 127)
      return {d[63], 31'h7F80_0000};
    m = {11'h0, 1'b1, d[51:0]};
    sh = (e >= -126) ? 29 : 29 + (-126 - e);
    if (sh > 60)
      return {d[63], 31'h0};
    q = m >> sh;
    rem = m & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0]))
      q = q + 64'd1;
    if (e < -126)
      return {d[63], q[30:0]};
    if (q == (64'd1 << 24)) begin
      q = q >> 1;
      e = e + 1;
    end
    if (e > 127)
      return {d[63], 31'h7F80_0000};
    return {d[63], 8'(e + 127), q[22:0]};
  endfunction

  function automatic logic [15:0] single_to_half(logic [31:0] u);
    logic [23:0] m24;
    int e;
    e = int'(u[30:23]) - 112;
    m24 = {1'b1, u[22:0]};
    if (e < -10)
      return {u[31], 15'h0};
    if (e <= 0)
      return {u[31], 15'(m24 >> (14 - e))};
    if (e >= 31)
      return {u[31], 15'h7C00};
    return {u[31], 15'((32'(e) << 10) + ((32'(u[22:0]) + 32'h1000) >> 13))};
  endfunction

  function automatic logic [3:0] nibble_of(real x);
    real a;
    int n;
    if (x != x)
      return 4'h0;
    if (x >= 7.0)
      return 4'h7;
    if (x <= -8.0)
      return 4'h8;
    a = (x < 0.0) ? -x : x;
    n = $rtoi(a);
    if (a - real'(n) >= 0.5)
      n++;
    if (x < 0.0)
      n = -n;
    return 4'(n);
  endfunction

  function automatic void push_result(kind_t k, int col, logic [15:0] pay, logic last);
    quant_result_t r;
    r.kind = k;
    r.row = row_cnt;
    r.col = 5'(col);
    r.pay = pay;
    r.last = last;
    pending_results = {pending_results, r};
  endfunction

  function automatic void predict_quantized_row(logic [31:0] sample);
    int len, nbytes;
    bit detect;
    bit outl[MAX_COLS];
    logic [31:0] a, peak;
    logic [7:0] b;
    real inv;
    len = (len_reg == 0) ? 1 : ((len_reg > MAX_COLS) ? MAX_COLS : int'(len_reg));
    if (col_cnt < MAX_COLS)
      row_buf[col_cnt] = sample;
    col_cnt++;
    if (col_cnt < len)
      return;
    detect = !thr_reg[31] && thr_reg[30:0] != 0
             && !(thr_reg[30:23] == 8'hFF && thr_reg[22:0] != 0);
    peak = '0;
    for (int c = 0; c < len; c++) begin
      a = row_buf[c] & 32'h7FFF_FFFF;
      outl[c] = 1'b0;
      if (a > 32'h7F80_0000)
        continue;
      outl[c] = detect && a > thr_reg;
      if (!outl[c] && a > peak)
        peak = a;
    end
    if (peak < FLOOR_BITS)
      peak = FLOOR_BITS;
    inv = single_to_real(real_to_single(7.0 / single_to_real(peak)));
    push_result(KIND_SCALE, 0,
                single_to_half(real_to_single(single_to_real(peak) / 7.0)), 1'b0);
    for (int c = 0; c < len; c++)
      if (outl[c])
        push_result(KIND_OUTL, c, single_to_half(row_buf[c]), 1'b0);
    nbytes = (len + 1) / 2;
    for (int c = 0; c < nbytes; c++) begin
      b = '0;
      for (int k = 2 * c; k < 2 * c + 2 && k < len; k++)
        if (!outl[k])
          b[(k % 2) * 4 +: 4] = nibble_of(single_to_real(real_to_single(
                                  single_to_real(row_buf[k]) * inv)));
      push_result(KIND_BYTE, 2 * c, {8'h00, b}, c + 1 == nbytes);
    end
    col_cnt = 0;
    row_cnt++;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycles, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    quant_result_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report("unexpected result, kind", 32'(out_tuser), 32'h0);
      end else begin
        w = pending_results.pop_front();
        if (out_tuser != w.kind)
          report("kind", 32'(out_tuser), 32'(w.kind));
        if (out_tdata[31:0] != w.row)
          report("row_index", out_tdata[31:0], w.row);
        if (out_tdata[36:32] != w.col)
          report("col_index", 32'(out_tdata[36:32]), 32'(w.col));
        if (out_tdata[52:37] != w.pay)
          report("payload", 32'(out_tdata[52:37]), 32'(w.pay));
        if (out_tlast != w.last)
          report("last_of_row", 32'(out_tlast), 32'(w.last));
      end
    end
  end

  task automatic send_sample(logic [31:0] v);
    if (!calm && $urandom_range(99) < 28) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_quantized_row(v);
    samples_sent++;
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_THRESH)
      thr_reg = val;
    else
      len_reg = val[5:0];
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_sample();
    int r;
    r = $urandom_range(99);
    if (r < 70)
      return {1'($urandom), 8'(118 + $urandom_range(16)), 23'($urandom)};
    if (r < 85)
      return $urandom;
    case ($urandom_range(5))
      0: return 32'h7F80_0000;
      1: return 32'hFFC0_0001;
      2: return 32'h0000_0001;
      3: return 32'h8000_0000;
      4: return 32'h7F7F_FFFF;
      default: return 32'h477F_F000;
    endcase
  endfunction

  task automatic test_specials;
    write_reg(CFG_ROWLEN, 32'd4);
    write_reg(CFG_THRESH, 32'h0);
    foreach (row_buf[i]) send_sample(32'h0);
    drain;
    send_sample(32'h8000_0000); send_sample(32'h0000_0001);
    send_sample(32'h7FC0_0001); send_sample(32'h3F80_0000);
    send_sample(32'h7F80_0000); send_sample(32'h40E0_0000);
    send_sample(32'hFF80_0000); send_sample(32'hBF00_0000);
    send_sample(32'h7F7F_FFFF); send_sample(32'hFFFF_FFFF);
    send_sample(32'h0080_0000); send_sample(32'hC0E0_0000);
  endtask

  task automatic test_outliers;
    drain;
    write_reg(CFG_THRESH, 32'h3F80_0000);
    write_reg(CFG_ROWLEN, 32'd3);
    send_sample(32'h477F_F000); send_sample(32'h3F00_0000); send_sample(32'hC780_1000);
    send_sample(32'h3F80_1000); send_sample(32'h3380_0000); send_sample(32'hBF40_0000);
    drain;
    write_reg(CFG_THRESH, 32'h7FC0_0000);
    write_reg(CFG_ROWLEN, 32'd0);
    send_sample(32'h4120_0000); send_sample(32'hBF20_0000);
    drain;
    write_reg(CFG_THRESH, 32'hBF80_0000);
    write_reg(CFG_ROWLEN, 32'd1);
    send_sample(32'h4120_0000);
  endtask

  task automatic test_shortened_row;
    drain;
    write_reg(CFG_ROWLEN, 32'd8);
    for (int i = 0; i < 5; i++) send_sample(rand_sample());
    drain;
    write_reg(CFG_ROWLEN, 32'd3);
    send_sample(rand_sample());
  endtask

  task automatic test_random_rows;
    int phase, len, rows;
    phase = 0;
    while (samples_sent < 420) begin
      drain;
      calm = (phase == 4);
      case ($urandom_range(6))
        0: write_reg(CFG_THRESH, 32'h0);
        1: write_reg(CFG_THRESH, 32'h7FC0_0000 | 32'($urandom_range(255)));
        2: write_reg(CFG_THRESH, 32'h7F80_0000);
        3: write_reg(CFG_THRESH, {1'b1, 31'($urandom)});
        default: write_reg(CFG_THRESH, {1'b0, 8'(122 + $urandom_range(8)), 23'($urandom)});
      endcase
      case ($urandom_range(7))
        0: write_reg(CFG_ROWLEN, 32'd63);
        1: write_reg(CFG_ROWLEN, 32'd32);
        2: write_reg(CFG_ROWLEN, 32'd1);
        3: write_reg(CFG_ROWLEN, 32'($urandom_range(63, 33)));
        default: write_reg(CFG_ROWLEN, 32'($urandom_range(9, 2)));
      endcase
      len = (len_reg == 0) ? 1 : ((len_reg > MAX_COLS) ? MAX_COLS : int'(len_reg));
      rows = (len > 9) ? 1 : $urandom_range(6, 2);
      for (int r = 0; r < rows * len; r++) send_sample(rand_sample());
      phase++;
    end
    calm = 1'b0;
  endtask

  initial begin
    thr_reg = '0;
    len_reg = 6'(MAX_COLS);
    col_cnt = 0;
    row_cnt = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_specials;
    test_outliers;
    test_shortened_row;
    test_random_rows;
    drain;
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
